FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_CLK_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/pcfd_pkg.sv
// Package: widths, register indexes, divider handshake types and saturation helpers.
package pcfd_pkg;

  localparam int ERR_W      = 16;
  localparam int OUT_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;
  localparam int DIV_W      = 32;
  localparam int DIV_CNT_W  = 6;
  localparam int ALPHA_W    = 17;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_TAU   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT   = 3'd6;

  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_RAW   = 6'd32;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_ALPHA = 6'd17;

  localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     rem_init;
    logic [DIV_W-1:0]     bits;
    logic [DIV_W-1:0]     divisor;
    logic [DIV_CNT_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return SAT_MAX;
    end else if (v < -66'sd2147483648) begin
      return SAT_MIN;
    end else begin
      return v[31:0];
    end
  endfunction

  // Sign-extend a 32-bit value to 36 bits.
  function automatic logic signed [35:0] sx36(input logic [31:0] x);
    return $signed({{4{x[31]}}, x});
  endfunction

  // Clamp to +/-lim; lim stays below 2^31, so this also covers 32-bit saturation.
  function automatic logic [31:0] clamp_mag(input logic signed [35:0] v,
                                            input logic [30:0] lim);
    logic signed [35:0] pos_l;
    logic signed [35:0] neg_l;
    pos_l = $signed({5'b00000, lim});
    neg_l = -pos_l;
    if (v > pos_l) begin
      return pos_l[31:0];
    end else if (v < neg_l) begin
      return neg_l[31:0];
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

FILE: hw/rtl/pcfd_if.sv
// Stream interfaces for the error sample input and the drive value output.
interface pcfd_err_if import pcfd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [ERR_W-1:0] error_sample;

  modport source(output valid, output error_sample, input ready);
  modport sink(input valid, input error_sample, output ready);
endinterface

interface pcfd_drive_if import pcfd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] drive_value;

  modport source(output valid, output drive_value, input ready);
  modport sink(input valid, input drive_value, output ready);
endinterface

FILE: hw/rtl/pid_controller_filtered_derivative.sv
// One PID channel in Q16.16 with a low-pass filtered derivative and anti-windup.
//
// Each accepted error_sample (signed integer) produces one drive_value (signed
// Q16.16): P = gain_p*e; with gain_i and step_time nonzero the integrator adds
// gain_i*e*step_time and is clamped to +/-integ_limit, otherwise it is cleared;
// with gain_d and step_time nonzero the raw derivative gain_d*(e-prev)/step_time
// is filtered with step_time/(deriv_filter_tau+step_time), otherwise the filtered
// derivative is held. P+I+D is clamped to +/-out_limit. Intermediates saturate to
// 32 bits. All work runs through one 33x33 signed multiplier and one radix-2
// divider under a sequencer, one item at a time: the input is not ready from
// acceptance until the result is loaded into the output register. A raw
// derivative too large for the divider skips the first division. The two
// divisions produce 32 and 17 quotient bits, one bit per cycle. The input is
// ready again the cycle after the result is loaded; a result still waiting in
// the output register holds the next one in its final state and adds its
// stall. The next item can be taken while the result waits in the output
// register. Configuration registers reset to zero and are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while the block is
// idle, which the block itself does not enforce; indexes beyond the list are
// ignored.
module pid_controller_filtered_derivative import pcfd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  pcfd_err_if.sink              err_in,
  pcfd_drive_if.source          drive_out,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [15:0] {
    S_IDLE           = 16'h0001,
    S_MUL_P          = 16'h0002,
    S_MUL_KIE        = 16'h0004,
    S_SAT_KIE        = 16'h0008,
    S_MUL_INC        = 16'h0010,
    S_ACC_ADD        = 16'h0020,
    S_ACC_CLAMP      = 16'h0040,
    S_MUL_KDD        = 16'h0080,
    S_SAT_KDD        = 16'h0100,
    S_DIV_RAW_GO     = 16'h0200,
    S_DIV_RAW_WAIT   = 16'h0400,
    S_DIV_ALPHA_GO   = 16'h0800,
    S_DIV_ALPHA_WAIT = 16'h1000,
    S_MUL_FD         = 16'h2000,
    S_FD_ADD         = 16'h4000,
    S_SUM_OUT        = 16'h8000
  } state_t;

  state_t state;
  state_t state_next;
  logic   load_out;

  // Configuration registers
  logic [CFG_DATA_W-1:0] gain_p;
  logic [CFG_DATA_W-1:0] gain_i;
  logic [CFG_DATA_W-1:0] gain_d;
  logic [CFG_DATA_W-1:0] step_time;
  logic [CFG_DATA_W-1:0] deriv_filter_tau;
  logic [CFG_DATA_W-1:0] integ_limit;
  logic [CFG_DATA_W-1:0] out_limit;

  // Loop state
  logic [31:0]       integ;
  logic [ERR_W-1:0]  prev;
  logic [31:0]       fd;

  // Working registers
  logic [ERR_W-1:0]     e_reg;
  logic signed [65:0]   prod;
  logic [31:0]          p_reg;
  logic [31:0]          tmp;
  logic signed [35:0]   wide;
  logic [31:0]          rawd;
  logic [ALPHA_W-1:0]   alpha;
  logic signed [32:0]   delta;
  logic [OUT_W-1:0]     drive;
  logic                 out_valid;
  logic                 sum_done;

  // Shared multiplier
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_p;

  logic               in_acc;
  logic               out_free;
  logic               i_en;
  logic               d_en;
  logic signed [16:0] diff;
  logic signed [65:0] shr;
  logic [31:0]        mag;
  logic               raw_ovf;
  logic signed [35:0] acc_sum;
  logic signed [35:0] fd_sum;
  logic signed [35:0] total;
  logic signed [32:0] delta_next;
  logic [31:0]        rawd_q;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign in_acc   = err_in.valid && err_in.ready;
  assign out_free = !out_valid || drive_out.ready;
  assign i_en     = (gain_i != '0) && (step_time != '0);
  assign d_en     = (gain_d != '0) && (step_time != '0);

  assign err_in.ready          = (state == S_IDLE);
  assign drive_out.valid       = out_valid;
  assign drive_out.drive_value = drive;

  assign diff       = $signed({e_reg[ERR_W-1], e_reg}) - $signed({prev[ERR_W-1], prev});
  assign shr        = prod >>> 16;   // floor division by 2^16
  assign mag        = tmp[31] ? (~tmp + 32'd1) : tmp;
  assign raw_ovf    = ({15'b0, mag[31:16]} >= step_time);
  assign acc_sum    = sx36(integ) + sx36(sat32(shr));
  assign fd_sum     = sx36(fd) + $signed(shr[35:0]);
  assign total      = sx36(p_reg) + sx36(integ) + sx36(fd);
  assign delta_next = $signed({rawd[31], rawd}) - $signed({fd[31], fd});
  assign mul_p      = mul_a * mul_b;

  // Signed raw derivative from the divider quotient, saturated to 32 bits.
  always_comb begin
    if (tmp[31]) begin
      if (div_rsp.quotient > SAT_MIN) begin
        rawd_q = SAT_MIN;
      end else begin
        rawd_q = ~div_rsp.quotient + 32'd1;
      end
    end else if (div_rsp.quotient[31]) begin
      rawd_q = SAT_MAX;
    end else begin
      rawd_q = div_rsp.quotient;
    end
  end

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MUL_P: begin
        mul_a = {2'b00, gain_p};
        mul_b = {{17{e_reg[ERR_W-1]}}, e_reg};
      end
      S_MUL_KIE: begin
        mul_a = {2'b00, gain_i};
        mul_b = {{17{e_reg[ERR_W-1]}}, e_reg};
      end
      S_MUL_INC: begin
        mul_a = {tmp[31], tmp};
        mul_b = {2'b00, step_time};
      end
      S_MUL_KDD: begin
        mul_a = {2'b00, gain_d};
        mul_b = {{16{diff[16]}}, diff};
      end
      S_MUL_FD: begin
        mul_a = {16'b0, alpha};
        mul_b = delta;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Divider requests: raw derivative (kdd<<16)/dt, then the filter coefficient
  // (dt<<16)/(tau+dt). Both preload the remainder so fewer steps are needed.
  always_comb begin
    div_req.start = ((state == S_DIV_RAW_GO) && !raw_ovf) || (state == S_DIV_ALPHA_GO);
    if (state == S_DIV_ALPHA_GO) begin
      div_req.rem_init = {2'b00, step_time[30:1]};
      div_req.bits     = {step_time[0], 31'b0};
      div_req.divisor  = {1'b0, deriv_filter_tau} + {1'b0, step_time};
      div_req.steps    = DIV_STEPS_ALPHA;
    end else begin
      div_req.rem_init = {16'b0, mag[31:16]};
      div_req.bits     = {mag[15:0], 16'b0};
      div_req.divisor  = {1'b0, step_time};
      div_req.steps    = DIV_STEPS_RAW;
    end
  end

  pcfd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:           if (in_acc) state_next = S_MUL_P;
      S_MUL_P:          state_next = S_MUL_KIE;
      S_MUL_KIE: begin
        if (i_en) begin
          state_next = S_SAT_KIE;
        end else if (d_en) begin
          state_next = S_MUL_KDD;
        end else begin
          state_next = S_SUM_OUT;
        end
      end
      S_SAT_KIE:        state_next = S_MUL_INC;
      S_MUL_INC:        state_next = S_ACC_ADD;
      S_ACC_ADD:        state_next = S_ACC_CLAMP;
      S_ACC_CLAMP:      state_next = d_en ? S_MUL_KDD : S_SUM_OUT;
      S_MUL_KDD:        state_next = S_SAT_KDD;
      S_SAT_KDD:        state_next = S_DIV_RAW_GO;
      S_DIV_RAW_GO:     state_next = raw_ovf ? S_DIV_ALPHA_GO : S_DIV_RAW_WAIT;
      S_DIV_RAW_WAIT:   if (div_rsp.done) state_next = S_DIV_ALPHA_GO;
      S_DIV_ALPHA_GO:   state_next = S_DIV_ALPHA_WAIT;
      S_DIV_ALPHA_WAIT: if (div_rsp.done) state_next = S_MUL_FD;
      S_MUL_FD:         state_next = S_FD_ADD;
      S_FD_ADD:         state_next = S_SUM_OUT;
      S_SUM_OUT:        if (load_out) state_next = S_IDLE;
      default:          state_next = S_IDLE;
    endcase
  end

  // SUM_OUT first forms P+I+D, then holds until the output register is free.
  assign load_out = (state == S_SUM_OUT) && sum_done && out_free;

  // Control and loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      sum_done  <= 1'b0;
      integ     <= '0;
      prev      <= '0;
      fd        <= '0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (drive_out.ready) begin
        out_valid <= 1'b0;
      end
      sum_done <= (state == S_SUM_OUT) && !load_out;
      if ((state == S_MUL_KIE) && !i_en) begin
        integ <= '0;
      end
      if (state == S_ACC_CLAMP) begin
        integ <= clamp_mag(wide, integ_limit);
      end
      if (state == S_FD_ADD) begin
        fd   <= sat32({{30{fd_sum[35]}}, fd_sum});
        prev <= e_reg;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE:       if (in_acc) e_reg <= err_in.error_sample;
      S_MUL_P:      prod <= mul_p;
      S_MUL_KIE: begin
        p_reg <= sat32(prod);
        prod  <= mul_p;
      end
      S_SAT_KIE:    tmp  <= sat32(prod);
      S_MUL_INC:    prod <= mul_p;
      S_ACC_ADD:    wide <= acc_sum;
      S_MUL_KDD:    prod <= mul_p;
      S_SAT_KDD:    tmp  <= sat32(prod);
      S_DIV_RAW_GO: if (raw_ovf) rawd <= tmp[31] ? SAT_MIN : SAT_MAX;
      S_DIV_RAW_WAIT: if (div_rsp.done) rawd <= rawd_q;
      S_DIV_ALPHA_WAIT: begin
        delta <= delta_next;
        if (div_rsp.done) alpha <= div_rsp.quotient[ALPHA_W-1:0];
      end
      S_MUL_FD:     prod <= mul_p;
      S_SUM_OUT: begin
        // first cycle: form the sum; later cycles: hold it until loaded
        if (!sum_done) wide <= total;
        if (load_out) drive <= clamp_mag(wide, out_limit);
      end
      default: ;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p           <= '0;
      gain_i           <= '0;
      gain_d           <= '0;
      step_time        <= '0;
      deriv_filter_tau <= '0;
      integ_limit      <= '0;
      out_limit        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN_P:      gain_p           <= cfg_data;
        REG_GAIN_I:      gain_i           <= cfg_data;
        REG_GAIN_D:      gain_d           <= cfg_data;
        REG_STEP_TIME:   step_time        <= cfg_data;
        REG_DERIV_TAU:   deriv_filter_tau <= cfg_data;
        REG_INTEG_LIMIT: integ_limit      <= cfg_data;
        REG_OUT_LIMIT:   out_limit        <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/pcfd_div.sv
// Radix-2 restoring divider: one quotient bit per cycle, preloadable remainder.
module pcfd_div import pcfd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] count;
  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     shift;
  logic [DIV_W-1:0]     divisor;
  logic [DIV_W-1:0]     quotient;
  logic [DIV_W:0]       trial;
  logic [DIV_W:0]       diff;
  logic                 ge;

  assign trial = {rem, shift[DIV_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= req.steps;
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == 1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem      <= req.rem_init;
      shift    <= req.bits;
      divisor  <= req.divisor;
      quotient <= '0;
    end else if (busy) begin
      rem      <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      shift    <= {shift[DIV_W-2:0], 1'b0};
      quotient <= {quotient[DIV_W-2:0], ge};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quotient;

endmodule

FILE: hw/rtl/pcfd_checker.sv
// Port-level checker for the PID channel, bound to the top level.
`include "assert_macros.svh"

module pcfd_checker import pcfd_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [OUT_W-1:0]      drive_value,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  logic [CFG_DATA_W-1:0] olim;
  logic signed [32:0]    dv;
  logic signed [32:0]    lim;
  logic                  in_band;

  // Track the output limit as written through the port.
  always_ff @(posedge clk) begin
    if (rst) begin
      olim <= '0;
    end else if (cfg_we && (cfg_index == REG_OUT_LIMIT)) begin
      olim <= cfg_data;
    end
  end

  assign dv      = $signed({drive_value[OUT_W-1], drive_value});
  assign lim     = $signed({2'b00, olim});
  assign in_band = (dv <= lim) && (dv >= -lim);

  `ASSERT_CLK(a_busy_after_accept, clk, rst, (in_valid && in_ready) |=> !in_ready, "input still ready after accepting an item")
  `ASSERT_CLK(a_out_hold, clk, rst, (out_valid && !out_ready) |=> (out_valid && $stable(drive_value)), "stalled result changed or dropped")
  `ASSERT_CLK(a_out_limit, clk, rst, out_valid |-> in_band, "drive value outside the output limit")
  `ASSERT_CLK_NR(a_reset_state, clk, rst |=> (!out_valid && in_ready), "block not idle after reset")

endmodule

bind pid_controller_filtered_derivative pcfd_checker u_pcfd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (err_in.valid),
  .in_ready    (err_in.ready),
  .out_valid   (drive_out.valid),
  .out_ready   (drive_out.ready),
  .drive_value (drive_out.drive_value),
  .cfg_we      (cfg_we),
  .cfg_index   (cfg_index),
  .cfg_data    (cfg_data)
);

FILE: tb/sv/testbench.sv
// Self-checking testbench for the filtered-derivative PID channel.
`timescale 1ns / 1ps

module testbench;
  import pcfd_pkg::*;

  // Register count and an index past the end of the register list.
  localparam int                   REG_COUNT   = 7;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 3'd7;
  localparam logic [30:0]          Q16_MAX     = 31'h7FFF_FFFF;
  localparam logic [30:0]          Q16_ONE     = 31'd65536;
  localparam int                   QUIET_LIMIT = 4000;
  localparam int                   RAND_BATCHES = 12;
  localparam int                   BATCH_ITEMS  = 38;
  localparam longint               S32_MAX = 64'sd2147483647;
  localparam longint               S32_MIN = -64'sd2147483648;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pcfd_err_if   err_ch();
  pcfd_drive_if drive_ch();

  pid_controller_filtered_derivative u_top (
    .clk       (clk),
    .rst       (rst),
    .err_in    (err_ch),
    .drive_out (drive_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the gain/limit registers and of the loop state.
  logic [30:0]        ctl_regs [REG_COUNT];
  logic signed [31:0] integ_sum;
  logic signed [15:0] held_error;
  logic signed [31:0] deriv_lp;

  // Error samples waiting to be sent, and drive values still owed by the block.
  logic signed [15:0] error_pending [$];
  logic signed [31:0] drive_owed [$];
  logic signed [31:0] want_drive;

  bit steady;
  int quiet_cycles;
  int mismatches;
  int items_sent;
  int drives_checked;
  int settings_used;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Saturate a wide value to the signed 32-bit range.
  function automatic longint clip32(input longint v);
    if (v > S32_MAX) begin
      return S32_MAX;
    end else if (v < S32_MIN) begin
      return S32_MIN;
    end
    return v;
  endfunction

  // Clamp to +/-lim; a zero limit forces zero.
  function automatic longint limit_mag(input longint v, input logic [30:0] lim);
    longint l;
    l = {33'b0, lim};
    if (v > l) begin
      return l;
    end else if (v < -l) begin
      return -l;
    end
    return v;
  endfunction

  // Advance the shadow loop state by one error sample and return the drive value.
  function automatic logic signed [31:0] pid_next_drive(input logic signed [15:0] err);
    longint e, kp, ki, kd, dt, tau, p, kie, inc, acc, diff, kdd, rawd, alpha, delta, sum;
    e   = longint'(err);
    kp  = {33'b0, ctl_regs[REG_GAIN_P]};
    ki  = {33'b0, ctl_regs[REG_GAIN_I]};
    kd  = {33'b0, ctl_regs[REG_GAIN_D]};
    dt  = {33'b0, ctl_regs[REG_STEP_TIME]};
    tau = {33'b0, ctl_regs[REG_DERIV_TAU]};
    p = clip32(kp * e);
    // Integrator: accumulate and clamp, or clear when disabled.
    if (ki != 0 && dt != 0) begin
      kie = clip32(ki * e);
      inc = clip32((kie * dt) >>> 16);
      acc = clip32(longint'(integ_sum) + inc);
      integ_sum = 32'(limit_mag(acc, ctl_regs[REG_INTEG_LIMIT]));
    end else begin
      integ_sum = '0;
    end
    // Derivative: raw slope through a first-order low-pass, else hold.
    if (kd != 0 && dt != 0) begin
      diff  = e - longint'(held_error);
      kdd   = clip32(kd * diff);
      rawd  = clip32((kdd * 65536) / dt);
      alpha = (dt <<< 16) / (tau + dt);
      delta = rawd - longint'(deriv_lp);
      deriv_lp   = 32'(clip32(longint'(deriv_lp) + ((alpha * delta) >>> 16)));
      held_error = err;
    end
    sum = clip32(p + longint'(integ_sum) + longint'(deriv_lp));
    return 32'(limit_mag(sum, ctl_regs[REG_OUT_LIMIT]));
  endfunction

  // Random register value: mostly typical magnitudes, sometimes zero, max or any bits.
  function automatic logic [30:0] pick_setting_value(input int unsigned typical_hi);
    case ($urandom_range(9))
      0: return '0;
      1: return Q16_MAX;
      2: return 31'($urandom);
      default: return 31'($urandom_range(typical_hi, 1));
    endcase
  endfunction

  // Write one register; hold the enable for exactly one edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [30:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx < REG_COUNT) begin
      ctl_regs[idx] = val;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_setting(input logic [30:0] kp, input logic [30:0] ki,
                              input logic [30:0] kd, input logic [30:0] dt,
                              input logic [30:0] tau, input logic [30:0] ilim,
                              input logic [30:0] olim);
    write_reg(REG_GAIN_P, kp);
    write_reg(REG_GAIN_I, ki);
    write_reg(REG_GAIN_D, kd);
    write_reg(REG_STEP_TIME, dt);
    write_reg(REG_DERIV_TAU, tau);
    write_reg(REG_INTEG_LIMIT, ilim);
    write_reg(REG_OUT_LIMIT, olim);
    settings_used++;
  endtask

  // Wait until every queued item went in and every drive value came back.
  // Look between edges so the driver and monitor updates have all settled.
  task automatic drain;
    do begin
      @(negedge clk);
    end while (error_pending.size() != 0 || err_ch.valid || drive_owed.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic send(input logic signed [15:0] sample);
    error_pending.push_back(sample);
  endtask

  // Driver: present the next pending error sample; predict on acceptance.
  always @(posedge clk) begin
    if (rst) begin
      err_ch.valid        <= 1'b0;
      err_ch.error_sample <= '0;
    end else begin
      if (err_ch.valid && err_ch.ready) begin
        drive_owed.push_back(pid_next_drive(err_ch.error_sample));
        items_sent++;
      end
      // Only advance once the current item is gone (or none is up).
      if (!err_ch.valid || err_ch.ready) begin
        if (error_pending.size() != 0 && (steady || $urandom_range(99) >= 30)) begin
          err_ch.valid        <= 1'b1;
          err_ch.error_sample <= error_pending.pop_front();
        end else begin
          err_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each drive value with the oldest owed one; stall at random.
  always @(posedge clk) begin
    if (rst) begin
      drive_ch.ready <= 1'b0;
    end else begin
      if (drive_ch.valid && drive_ch.ready) begin
        drives_checked++;
        if (drive_owed.size() == 0) begin
          $error("drive_value %0d arrived with no item outstanding",
                 drive_ch.drive_value);
          mismatches++;
        end else begin
          want_drive = drive_owed.pop_front();
          if (drive_ch.drive_value !== want_drive) begin
            $error("drive_value mismatch: expected %0d actual %0d",
                   want_drive, drive_ch.drive_value);
            mismatches++;
          end
        end
      end
      drive_ch.ready <= steady || ($urandom_range(99) >= 30);
    end
  end

  // Watchdog: end the run if neither side moves an item for too long.
  always @(posedge clk) begin
    if (rst || (err_ch.valid && err_ch.ready) || (drive_ch.valid && drive_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d idle cycles", quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int walk;
    int b;
    int n;
    logic signed [15:0] sample;

    // Every input known from time zero; reset once.
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    err_ch.valid        = 1'b0;
    err_ch.error_sample = '0;
    drive_ch.ready      = 1'b0;
    steady              = 1'b0;
    quiet_cycles        = 0;
    mismatches          = 0;
    items_sent          = 0;
    drives_checked      = 0;
    settings_used       = 1;
    walk                = 0;
    integ_sum           = '0;
    held_error          = '0;
    deriv_lp            = '0;
    for (int i = 0; i < REG_COUNT; i++) begin
      ctl_regs[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset values: zero output limit forces a zero drive value.
    send(16'sh7FFF);
    send(16'sh8000);
    drain();

    // Pure proportional, unit gain; the write past the list must be dropped.
    load_setting(Q16_ONE, '0, '0, '0, '0, '0, Q16_MAX);
    write_reg(REG_UNUSED, Q16_MAX);
    send(16'sd0);
    send(16'sd1);
    send(-16'sd1);
    send(16'sh7FFF);
    send(16'sh8000);
    drain();

    // Zero step time with I and D gains set: integrator cleared, derivative held.
    load_setting(Q16_MAX, Q16_ONE, Q16_ONE, '0, '0, Q16_MAX, Q16_MAX);
    send(16'sh7FFF);
    send(16'sh8000);
    send(16'sd5);
    drain();

    // Integrator alone, running into its +/-10.0 clamp from both sides.
    load_setting('0, Q16_ONE, '0, Q16_ONE, '0, 31'd10 << 16, Q16_MAX);
    send(16'sd3);
    send(16'sd3);
    send(16'sd3);
    send(16'sd5);
    send(16'sh8000);
    send(-16'sd7);
    drain();

    // Derivative alone, no filtering (zero time constant), dt = 0.1.
    load_setting('0, '0, Q16_ONE, 31'd6554, '0, '0, Q16_MAX);
    send(16'sd100);
    send(-16'sd100);
    send(16'sh7FFF);
    drain();

    // Smallest step time against the longest time constant.
    load_setting('0, '0, Q16_MAX, 31'd1, Q16_MAX, '0, Q16_MAX);
    send(16'sh8000);
    send(16'sh7FFF);
    drain();

    // Zero integrator limit pins I at zero; I and D gains, step time and time constant at their top.
    load_setting(Q16_ONE, Q16_MAX, Q16_MAX, Q16_MAX, Q16_MAX, '0, 31'd1000 << 16);
    send(16'sd20);
    send(16'sh8000);
    send(16'sh7FFF);
    send(16'sd0);
    drain();

    // Random settings; smooth error walks and noise, some extremes.
    for (b = 0; b < RAND_BATCHES; b++) begin
      steady = (b == 4);
      load_setting(pick_setting_value(32'd262144), pick_setting_value(32'd262144),
                   pick_setting_value(32'd262144), pick_setting_value(32'd65536),
                   pick_setting_value(32'd262144), pick_setting_value(32'd65536000),
                   pick_setting_value(32'd131072000));
      for (n = 0; n < BATCH_ITEMS; n++) begin
        case ($urandom_range(9))
          0: sample = 16'($urandom);
          1: sample = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
          2, 3, 4, 5: begin
            walk = walk + int'($urandom_range(40)) - 20;
            if (walk > 2000) begin
              walk = 2000;
            end else if (walk < -2000) begin
              walk = -2000;
            end
            sample = 16'(walk);
          end
          default: sample = 16'(int'($urandom_range(600)) - 300);
        endcase
        send(sample);
      end
      drain();
    end
    steady = 1'b0;

    // Let any straggler show up before the verdict.
    repeat (100) @(posedge clk);
    if (drive_owed.size() != 0) begin
      $error("%0d drive values never arrived", drive_owed.size());
      mismatches++;
    end

    $display("Ran %0d error samples through %0d gain/limit settings, %0d drive values checked.",
             items_sent, settings_used, drives_checked);
    $display("Mismatching drive values: %0d", mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/pcfd_pkg.sv
hw/rtl/pcfd_if.sv
hw/rtl/pcfd_div.sv
hw/rtl/pid_controller_filtered_derivative.sv
hw/rtl/pcfd_checker.sv
tb/sv/testbench.sv
